// ===== design/ipl_pkg.sv =====
// Shared constants, codes and types of the initial range planner.
package ipl_pkg;

    // Span table and offset sizing.
    localparam int MAX_SPANS = 64;
    localparam int IDX_W     = $clog2(MAX_SPANS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OFF_BITS  = 48;
    localparam int POS_W     = OFF_BITS + 1;
    localparam int LEN_W     = POS_W + 1;
    localparam int BIT_W     = $clog2(POS_W);

    // Register widths and configuration port.
    localparam int UNIT_W    = 25;
    localparam int LIM_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ITEM,
        OP_CLEAR,
        OP_MAX_START,
        OP_DIV_START,
        OP_MID,
        OP_WR_LO,
        OP_WR_HI,
        OP_CNT_START,
        OP_MIN_START,
        OP_EMIT_SPAN,
        OP_EMIT_WHOLE,
        OP_EMIT_ERR,
        OP_EMIT_EMPTY
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic div_busy;
        logic mode;
        logic ovf;
        logic split_go;
        logic len_ok;
        logic mid_ok;
        logic no_valid;
        logic final_pick;
        logic out_free;
    } t_stat;

endpackage

// ===== design/ipl_in_if.sv =====
// Request channel carrying one bitmap flag per block.
interface ipl_in_if;
    logic valid;
    logic ready;
    logic block_done;
    logic last_block;

    modport source (output valid, output block_done, output last_block, input ready);
    modport sink (input valid, input block_done, input last_block, output ready);
endinterface

// ===== design/ipl_out_if.sv =====
// Request channel carrying one planned byte range.
interface ipl_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] range_begin;
    logic [48:0] range_end;
    logic        plan_empty;
    logic        plan_error;
    logic        last_range;

    modport source (output valid, output range_begin, output range_end, output plan_empty,
                    output plan_error, output last_range, input ready);
    modport sink (input valid, input range_begin, input range_end, input plan_empty,
                  input plan_error, input last_range, output ready);
endinterface

// ===== design/ipl_datapath.sv =====
// Datapath: configuration, bitmap scan, span table, split arithmetic and result register.
module ipl_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipl_pkg::CFG_W-1:0]     i_cfg_data,
    input  ipl_pkg::t_cmd                 i_cmd,
    input  logic                          i_block_done,
    input  logic                          i_last_block,
    input  logic                          i_out_ready,
    output ipl_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [ipl_pkg::OFF_BITS-1:0]  o_range_begin,
    output logic [ipl_pkg::POS_W-1:0]     o_range_end,
    output logic                          o_plan_empty,
    output logic                          o_plan_error,
    output logic                          o_last_range
);
    import ipl_pkg::*;

    localparam logic [POS_W-1:0] OFF_LIMIT = {1'b1, {OFF_BITS{1'b0}}};

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] end1;
    } t_span;

    typedef enum logic [1:0] {P_MAX, P_CNT, P_MIN} t_pass;

    // Configuration registers.
    logic                r_mode;
    logic [OFF_BITS-1:0] r_total;
    logic [UNIT_W-1:0]   r_bb;
    logic [LIM_W-1:0]    r_limit;

    // Scan state.
    logic [CNT_W-1:0]    r_count;
    logic [POS_W-1:0]    r_open_start;
    logic                r_open;
    logic [OFF_BITS-1:0] r_blk;
    logic [POS_W-1:0]    r_off;
    logic                r_ovf;

    // Span table.
    t_span               r_mem [MAX_SPANS];
    t_span               r_rdata;

    // Table walk.
    logic                r_run;
    t_pass               r_kind;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_pv;
    logic [IDX_W-1:0]    r_pidx;

    // Largest span.
    logic [IDX_W-1:0]        r_best_i;
    logic [POS_W-1:0]        r_best_s;
    logic [POS_W-1:0]        r_best_e;
    logic signed [LEN_W-1:0] r_best_len;

    // Remainder unit and split point.
    logic [POS_W-1:0]    r_v;
    logic [UNIT_W-1:0]   r_rem;
    logic [BIT_W-1:0]    r_dbit;
    logic                r_dbusy;
    logic [POS_W:0]      r_mid;

    // Ordered emission.
    logic [CNT_W-1:0]    r_nvalid;
    logic [CNT_W-1:0]    r_emitted;
    logic                r_have_prev;
    logic [POS_W-1:0]    r_prev_s;
    logic [IDX_W-1:0]    r_prev_i;
    logic                r_found;
    logic [POS_W-1:0]    r_cand_s;
    logic [POS_W-1:0]    r_cand_e;
    logic [IDX_W-1:0]    r_cand_i;

    // Result register.
    logic                r_ov;
    logic [OFF_BITS-1:0] r_o_begin;
    logic [POS_W-1:0]    r_o_end;
    logic                r_o_empty;
    logic                r_o_err;
    logic                r_o_last;

    logic [UNIT_W-1:0]       w_unit;
    logic [CNT_W-1:0]        w_lim;
    logic [POS_W-1:0]        w_total;
    logic [POS_W-1:0]        w_clip;
    logic [POS_W:0]          w_sum;
    logic [POS_W-1:0]        w_off_nxt;
    logic                    w_full;
    logic                    w_store;
    t_span                   w_new;
    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    t_span                   w_wdata;
    logic                    w_issue;
    logic signed [LEN_W-1:0] w_len;
    logic                    w_ent_ok;
    logic                    w_after;
    logic [POS_W-1:0]        w_v;
    logic [UNIT_W:0]         w_trial;
    logic [UNIT_W-1:0]       w_adj;
    logic                    w_load;
    logic                    w_start;

    // A block size of zero acts as one; the limit is capped at the table size.
    assign w_unit  = (r_bb == '0) ? UNIT_W'(1) : r_bb;
    assign w_lim   = (int'(r_limit) > MAX_SPANS) ? CNT_W'(MAX_SPANS) : CNT_W'(r_limit);
    assign w_total = {1'b0, r_total};

    // Scan arithmetic: span ends clip to the file size, offsets saturate.
    assign w_clip    = (r_off < w_total) ? r_off : w_total;
    assign w_sum     = (POS_W+1)'(r_off) + (POS_W+1)'(w_unit);
    assign w_off_nxt = (w_sum > (POS_W+1)'(OFF_LIMIT)) ? OFF_LIMIT : w_sum[POS_W-1:0];
    assign w_full    = (r_count >= CNT_W'(MAX_SPANS));

    always_comb begin
        w_store = 1'b0;
        w_new   = '0;
        if (i_block_done && r_open) begin
            w_store = 1'b1;
            w_new   = '{start: r_open_start, end1: w_clip};
        end else if (!i_block_done && i_last_block) begin
            w_store = 1'b1;
            w_new   = '{start: (r_open ? r_open_start : r_off), end1: w_total};
        end
    end

    // Span table write port.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IDX_W-1:0];
        w_wdata = w_new;
        case (i_cmd.op)
            OP_ITEM: begin
                w_we = w_store && !w_full;
            end
            OP_WR_LO: begin
                w_we    = 1'b1;
                w_waddr = r_best_i;
                w_wdata = '{start: r_best_s, end1: r_mid[POS_W-1:0]};
            end
            OP_WR_HI: begin
                w_we    = 1'b1;
                w_wdata = '{start: r_mid[POS_W-1:0], end1: r_best_e};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Entry under inspection during a table walk.
    assign w_issue  = r_run && (r_ptr < r_count);
    assign w_len    = $signed({1'b0, r_rdata.end1}) - $signed({1'b0, r_rdata.start});
    assign w_ent_ok = r_rdata.start < r_rdata.end1;
    assign w_after  = !r_have_prev || (r_rdata.start > r_prev_s) ||
                      ((r_rdata.start == r_prev_s) && (r_pidx > r_prev_i));

    // Split point before alignment, and the restoring remainder step.
    assign w_v     = r_best_s + r_best_len[POS_W:1];
    assign w_trial = {r_rem, r_v[r_dbit]};
    assign w_adj   = (r_rem == '0) ? '0 : (w_unit - r_rem);

    assign w_load  = (i_cmd.op == OP_EMIT_SPAN) || (i_cmd.op == OP_EMIT_WHOLE) ||
                     (i_cmd.op == OP_EMIT_ERR) || (i_cmd.op == OP_EMIT_EMPTY);
    assign w_start = (i_cmd.op == OP_MAX_START) || (i_cmd.op == OP_CNT_START) ||
                     (i_cmd.op == OP_MIN_START) || (i_cmd.op == OP_EMIT_SPAN);

    // Span table storage with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_ptr[IDX_W-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_total <= '0;
            r_bb    <= UNIT_W'(65536);
            r_limit <= LIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_TOTAL: r_total <= i_cfg_data[OFF_BITS-1:0];
                REG_BLOCK: r_bb    <= i_cfg_data[UNIT_W-1:0];
                REG_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // Bitmap scan and span count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_open_start <= '0;
            r_open       <= 1'b0;
            r_blk        <= '0;
            r_off        <= '0;
            r_ovf        <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ITEM: begin
                    if (w_store) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    if (i_last_block) begin
                        r_open <= 1'b0;
                        r_blk  <= '0;
                        r_off  <= '0;
                    end else begin
                        if (i_block_done) begin
                            r_open <= 1'b0;
                        end else if (!r_open) begin
                            r_open       <= 1'b1;
                            r_open_start <= r_off;
                        end
                        if (r_blk != '1) begin
                            r_blk <= r_blk + 1'b1;
                            r_off <= w_off_nxt;
                        end
                    end
                end
                OP_WR_HI: begin
                    r_count <= r_count + 1'b1;
                end
                OP_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Table walk sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pv  <= 1'b0;
            r_ptr <= '0;
        end else if (w_start) begin
            r_run <= 1'b1;
            r_pv  <= 1'b0;
            r_ptr <= '0;
        end else if (r_run) begin
            r_pv <= w_issue;
            if (w_issue) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (!w_issue && !r_pv) begin
                r_run <= 1'b0;
            end
        end
    end

    // Walk kind and per-entry work: largest span, valid count, next in order.
    always_ff @(posedge i_clk) begin
        r_pidx <= r_ptr[IDX_W-1:0];
        case (i_cmd.op)
            OP_MAX_START: begin
                r_kind <= P_MAX;
            end
            OP_CNT_START: begin
                r_kind      <= P_CNT;
                r_nvalid    <= '0;
                r_emitted   <= '0;
                r_have_prev <= 1'b0;
            end
            OP_MIN_START: begin
                r_kind  <= P_MIN;
                r_found <= 1'b0;
            end
            OP_EMIT_SPAN: begin
                r_kind      <= P_MIN;
                r_found     <= 1'b0;
                r_have_prev <= 1'b1;
                r_prev_s    <= r_cand_s;
                r_prev_i    <= r_cand_i;
                r_emitted   <= r_emitted + 1'b1;
            end
            default: begin
                if (r_pv) begin
                    case (r_kind)
                        P_MAX: begin
                            if ((r_pidx == '0) || (w_len > r_best_len)) begin
                                r_best_i   <= r_pidx;
                                r_best_s   <= r_rdata.start;
                                r_best_e   <= r_rdata.end1;
                                r_best_len <= w_len;
                            end
                        end
                        P_CNT: begin
                            if (w_ent_ok) begin
                                r_nvalid <= r_nvalid + 1'b1;
                            end
                        end
                        P_MIN: begin
                            if (w_ent_ok && w_after && (!r_found || (r_rdata.start < r_cand_s)))
                            begin
                                r_found  <= 1'b1;
                                r_cand_s <= r_rdata.start;
                                r_cand_e <= r_rdata.end1;
                                r_cand_i <= r_pidx;
                            end
                        end
                        default: begin
                            r_found <= r_found;
                        end
                    endcase
                end
            end
        endcase
    end

    // Remainder of the split point by the block size, one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.op == OP_DIV_START) begin
            r_dbusy <= 1'b1;
            r_v     <= w_v;
            r_rem   <= '0;
            r_dbit  <= BIT_W'(POS_W - 1);
        end else if (r_dbusy) begin
            if (w_trial >= {1'b0, w_unit}) begin
                r_rem <= UNIT_W'(w_trial - {1'b0, w_unit});
            end else begin
                r_rem <= w_trial[UNIT_W-1:0];
            end
            if (r_dbit == '0) begin
                r_dbusy <= 1'b0;
            end else begin
                r_dbit <= r_dbit - 1'b1;
            end
        end
    end

    // Aligned split point.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MID) begin
            r_mid <= (POS_W+1)'(r_v) + (POS_W+1)'(w_adj);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_EMIT_SPAN: begin
                r_o_begin <= r_cand_s[OFF_BITS-1:0];
                r_o_end   <= r_cand_e;
                r_o_empty <= 1'b0;
                r_o_err   <= 1'b0;
                r_o_last  <= o_stat.final_pick;
            end
            OP_EMIT_WHOLE: begin
                r_o_begin <= '0;
                r_o_end   <= w_total;
                r_o_empty <= (r_total == '0);
                r_o_err   <= 1'b0;
                r_o_last  <= 1'b1;
            end
            OP_EMIT_ERR, OP_EMIT_EMPTY: begin
                r_o_begin <= '0;
                r_o_end   <= '0;
                r_o_empty <= 1'b1;
                r_o_err   <= (i_cmd.op == OP_EMIT_ERR);
                r_o_last  <= 1'b1;
            end
            default: begin
                r_o_last <= r_o_last;
            end
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_stat.busy       = r_run;
        o_stat.div_busy   = r_dbusy;
        o_stat.mode       = r_mode;
        o_stat.ovf        = r_ovf;
        o_stat.split_go   = (w_lim > CNT_W'(1)) && (r_count != '0) && (r_count < w_lim);
        o_stat.len_ok     = r_best_len >= $signed({{(LEN_W-UNIT_W-1){1'b0}}, w_unit, 1'b0});
        o_stat.mid_ok     = (r_mid < {1'b0, r_best_e}) && (r_mid > {1'b0, r_best_s});
        o_stat.no_valid   = (r_nvalid == '0);
        o_stat.final_pick = ((r_emitted + 1'b1) == r_nvalid);
        o_stat.out_free   = !r_ov || i_out_ready;
    end

    assign o_out_valid   = r_ov;
    assign o_range_begin = r_o_begin;
    assign o_range_end   = r_o_end;
    assign o_plan_empty  = r_o_empty;
    assign o_plan_error  = r_o_err;
    assign o_last_range  = r_o_last;

    // The span count never passes the table size.
    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPANS))
        else $error("span count beyond table size");

    // The table walk and the remainder unit never run together.
    ap_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_dbusy))
        else $error("walk and remainder unit busy at once");

    // A new result is loaded only when the register is empty or the held one leaves.
    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_ov || i_out_ready))
        else $error("result register overwritten");

    // Writing the upper half of a split adds one span.
    ap_split_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_WR_HI) |=> (r_count == $past(r_count) + 1'b1))
        else $error("split did not add a span");

endmodule

// ===== design/ipl_ctrl.sv =====
// Controller: sequences scan, split loop, ordered emission and cleanup.
module ipl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last_block,
    input  ipl_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output ipl_pkg::t_cmd  o_cmd
);
    import ipl_pkg::*;

    typedef enum logic [3:0] {
        S_SCAN,
        S_PLAN,
        S_MAX,
        S_CHK,
        S_DIV,
        S_TEST,
        S_WRHI,
        S_NEXT,
        S_CNT,
        S_MIN,
        S_EMIT,
        S_WHOLE,
        S_ERR,
        S_EMPTY,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_SCAN);

    // Next state and the operation for this cycle.
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_SCAN: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ITEM;
                    if (i_last_block) begin
                        n_state = S_PLAN;
                    end
                end
            end
            S_PLAN: begin
                if (!i_stat.mode) begin
                    n_state = S_WHOLE;
                end else if (i_stat.ovf) begin
                    n_state = S_ERR;
                end else if (i_stat.split_go) begin
                    o_cmd.op = OP_MAX_START;
                    n_state  = S_MAX;
                end else begin
                    o_cmd.op = OP_CNT_START;
                    n_state  = S_CNT;
                end
            end
            S_MAX: begin
                if (!i_stat.busy) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.len_ok) begin
                    o_cmd.op = OP_DIV_START;
                    n_state  = S_DIV;
                end else begin
                    o_cmd.op = OP_CNT_START;
                    n_state  = S_CNT;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_MID;
                    n_state  = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.mid_ok) begin
                    o_cmd.op = OP_WR_LO;
                    n_state  = S_WRHI;
                end else begin
                    o_cmd.op = OP_CNT_START;
                    n_state  = S_CNT;
                end
            end
            S_WRHI: begin
                o_cmd.op = OP_WR_HI;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                if (i_stat.split_go) begin
                    o_cmd.op = OP_MAX_START;
                    n_state  = S_MAX;
                end else begin
                    o_cmd.op = OP_CNT_START;
                    n_state  = S_CNT;
                end
            end
            S_CNT: begin
                if (!i_stat.busy) begin
                    if (i_stat.no_valid) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd.op = OP_MIN_START;
                        n_state  = S_MIN;
                    end
                end
            end
            S_MIN: begin
                if (!i_stat.busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_SPAN;
                    n_state  = i_stat.final_pick ? S_DONE : S_MIN;
                end
            end
            S_WHOLE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_WHOLE;
                    n_state  = S_DONE;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_ERR;
                    n_state  = S_DONE;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT_EMPTY;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_SCAN;
            end
            default: begin
                n_state = S_SCAN;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SCAN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/initial_range_planner_top.sv =====
// Top level of the initial range planner.
//
// Usage: i_blk_ch takes one request per block, flag block_done and marker
// last_block, in block order. While scanning, one request is taken every
// cycle; runs of unfinished blocks are collected into a 64-entry span table.
// The request that carries last_block starts the plan, and i_blk_ch.ready
// stays low until the plan's final result has been handed to the result
// register. The plan splits the largest span until the connection limit is
// reached or the largest span cannot be split; each split takes a table walk
// and its handoff, a bit-serial remainder step and control states. Ordered
// output takes a counting walk and then one table walk per range. Results
// leave through o_rng_ch from a result register; when the receiver stalls
// the planner holds that request and waits.
// Configuration is written through i_cfg_* while idle. Reset clears the
// scan state and loads register defaults; the span table needs no clearing.
module initial_range_planner_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ipl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipl_pkg::CFG_W-1:0]     i_cfg_data,
    ipl_in_if.sink                        i_blk_ch,
    ipl_out_if.source                     o_rng_ch
);
    import ipl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // Controller.
    ipl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_blk_ch.valid),
        .i_last_block(i_blk_ch.last_block),
        .i_stat      (w_stat),
        .o_in_ready  (w_in_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    ipl_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .i_block_done (i_blk_ch.block_done),
        .i_last_block (i_blk_ch.last_block),
        .i_out_ready  (o_rng_ch.ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_rng_ch.valid),
        .o_range_begin(o_rng_ch.range_begin),
        .o_range_end  (o_rng_ch.range_end),
        .o_plan_empty (o_rng_ch.plan_empty),
        .o_plan_error (o_rng_ch.plan_error),
        .o_last_range (o_rng_ch.last_range)
    );

    assign i_blk_ch.ready = w_in_ready;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the initial range planner: block flags in, planned ranges out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ipl_pkg::*;

    typedef struct packed {
        logic [47:0] rbeg;
        logic [48:0] rend;
        logic        empty;
        logic        err;
        logic        last;
    } t_range;

    typedef struct {
        logic done;
        logic last;
    } t_flag;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_MODE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    ipl_in_if blk_ch ();
    ipl_out_if rng_ch ();

    initial_range_planner_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_blk_ch(blk_ch.sink), .o_rng_ch(rng_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    localparam longint OFF_LIM = 64'd1 << OFF_BITS;

    // Planner shadow state.
    logic          pl_mode = 1'b1;
    logic [47:0]   pl_total = '0;
    logic [24:0]   pl_block = 25'd65536;
    logic [6:0]    pl_limit = 7'd1;
    longint        sp_start[MAX_SPANS];
    longint        sp_lastb[MAX_SPANS];
    int            sp_count = 0;
    longint        open_start = 0;
    bit            span_open = 0;
    longint        blk_num = 0;
    bit            ovf_seen = 0;

    t_flag  flag_q[$];
    t_range ranges_q[$];
    int     errors = 0;
    int     mismatches = 0;
    bit     tx_hold = 0;
    bit     tx_acc = 0;
    bit     rx_hold = 0;
    bit     quiet = 0;
    int     idle_gap = 0;

    function automatic longint unit_size();
        return (pl_block == 0) ? 64'd1 : longint'(pl_block);
    endfunction

    function automatic void push_range(longint b, longint e, bit em, bit er, bit l);
        t_range r;
        r.rbeg = b[47:0];
        r.rend = e[48:0];
        r.empty = em;
        r.err = er;
        r.last = l;
        ranges_q = {ranges_q, r};
    endfunction

    function automatic void save_span(longint s, longint e);
        if (sp_count >= MAX_SPANS) begin
            ovf_seen = 1;
        end else begin
            sp_start[sp_count] = s;
            sp_lastb[sp_count] = e;
            sp_count++;
        end
    endfunction

    function automatic void reset_scan();
        sp_count = 0;
        open_start = 0;
        span_open = 0;
        blk_num = 0;
        ovf_seen = 0;
    endfunction

    // Split the widest span repeatedly, then order spans by start.
    function automatic void split_and_sort();
        longint u, lim, s, e, len, v, r, adj, mid;
        int best, j;
        u = unit_size();
        lim = (pl_limit > MAX_SPANS) ? MAX_SPANS : pl_limit;
        if (lim > 1 && sp_count > 0) begin
            while (sp_count < lim) begin
                best = 0;
                for (int i = 1; i < sp_count; i++)
                    if (sp_lastb[i] - sp_start[i] > sp_lastb[best] - sp_start[best])
                        best = i;
                s = sp_start[best];
                e = sp_lastb[best];
                len = e - s + 1;
                if (len < 2 * u) break;
                v = s + len / 2;
                r = v % u;
                adj = (r == 0) ? 0 : u - r;
                if (adj > e - v) break;
                mid = v + adj;
                if (mid <= s) break;
                sp_lastb[best] = mid - 1;
                sp_start[sp_count] = mid;
                sp_lastb[sp_count] = e;
                sp_count++;
            end
        end
        for (int i = 1; i < sp_count; i++) begin
            s = sp_start[i];
            e = sp_lastb[i];
            j = i;
            while (j > 0 && sp_start[j-1] > s) begin
                sp_start[j] = sp_start[j-1];
                sp_lastb[j] = sp_lastb[j-1];
                j--;
            end
            sp_start[j] = s;
            sp_lastb[j] = e;
        end
    endfunction

    // Advance the scan by one block flag and queue any planned ranges.
    function automatic void plan_block(logic done, logic last);
        longint total, off, u, endb;
        int nvalid, k;
        total = longint'(pl_total);
        if (total >= OFF_LIM) total = OFF_LIM - 1;
        u = unit_size();
        off = (blk_num > OFF_LIM / u) ? OFF_LIM : blk_num * u;
        if (done) begin
            if (span_open) begin
                endb = (off < total) ? off : total;
                save_span(open_start, endb - 1);
                span_open = 0;
            end
        end else if (!span_open) begin
            open_start = off;
            span_open = 1;
        end
        if (blk_num < OFF_LIM - 1) blk_num++;
        if (!last) return;
        if (span_open) begin
            save_span(open_start, total - 1);
            span_open = 0;
        end
        if (!pl_mode) begin
            if (total > 0) push_range(0, total, 0, 0, 1);
            else push_range(0, 0, 1, 0, 1);
        end else if (ovf_seen) begin
            push_range(0, 0, 1, 1, 1);
        end else begin
            split_and_sort();
            nvalid = 0;
            for (int i = 0; i < sp_count; i++)
                if (sp_start[i] <= sp_lastb[i]) nvalid++;
            if (nvalid == 0) begin
                push_range(0, 0, 1, 0, 1);
            end else begin
                k = 0;
                for (int i = 0; i < sp_count; i++)
                    if (sp_start[i] <= sp_lastb[i]) begin
                        k++;
                        push_range(sp_start[i], sp_lastb[i] + 1, 0, 0, k == nvalid);
                    end
            end
        end
        reset_scan();
    endfunction

    // Remember whether the offered flag was taken at the last rising edge.
    always @(posedge i_clk) begin
        tx_acc <= i_rst_n && blk_ch.valid && blk_ch.ready;
    end

    // Driver: present queued flags at the falling edge, with random gaps.
    initial begin
        blk_ch.valid = 1'b0;
        blk_ch.block_done = 1'b0;
        blk_ch.last_block = 1'b0;
    end
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (tx_acc) void'(flag_q.pop_front());
            if (!blk_ch.valid || tx_acc) begin
                if (flag_q.size() > 0 && !tx_hold && (quiet || $urandom_range(99) >= 11)) begin
                    blk_ch.valid <= 1'b1;
                    blk_ch.block_done <= flag_q[0].done;
                    blk_ch.last_block <= flag_q[0].last;
                end else begin
                    blk_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready with random stalls and an optional long hold-off.
    initial rng_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) rng_ch.ready <= 1'b0;
        else rng_ch.ready <= !rx_hold && (quiet || $urandom_range(99) >= 11);
    end

    // Monitor: predict on accepted flags, compare accepted ranges.
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        t_range got, want;
        if (i_rst_n) begin
            stall_cycles++;
            if (blk_ch.valid && blk_ch.ready) begin
                stall_cycles = 0;
                plan_block(blk_ch.block_done, blk_ch.last_block);
            end
            if (rng_ch.valid && rng_ch.ready) begin
                stall_cycles = 0;
                got.rbeg = rng_ch.range_begin;
                got.rend = rng_ch.range_end;
                got.empty = rng_ch.plan_empty;
                got.err = rng_ch.plan_error;
                got.last = rng_ch.last_range;
                if (ranges_q.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("Unexpected range: begin=%0h end=%0h", got.rbeg, got.rend);
                end else begin
                    want = ranges_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("Range mismatch: exp %0h/%0h e%0b r%0b l%0b got %0h/%0h e%0b r%0b l%0b",
                                want.rbeg, want.rend, want.empty, want.err, want.last,
                                got.rbeg, got.rend, got.empty, got.err, got.last);
                    end
                end
            end
            if (stall_cycles > 50000) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:  pl_mode = val[0];
            REG_TOTAL: pl_total = val[47:0];
            REG_BLOCK: pl_block = val[24:0];
            REG_LIMIT: pl_limit = val[6:0];
            default:   pl_limit = pl_limit;
        endcase
    endtask

    task automatic drain();
        wait (flag_q.size() == 0 && !blk_ch.valid);
        wait (ranges_q.size() == 0);
        repeat (4200) @(posedge i_clk);
    endtask

    task automatic add_bitmap(int nblk, int pct_done);
        t_flag f;
        for (int i = 0; i < nblk; i++) begin
            f.done = ($urandom_range(99) < pct_done);
            f.last = (i == nblk - 1);
            flag_q = {flag_q, f};
        end
    endtask

    task automatic add_flag(logic d, logic l);
        t_flag f;
        f.done = d;
        f.last = l;
        flag_q = {flag_q, f};
    endtask

    // Random configuration; most draws size the file so that the bitmap roughly covers it.
    task automatic random_cfg(int nblk);
        logic [24:0] bb;
        logic [47:0] tb;
        bb = ($urandom_range(3) == 0) ? 25'($urandom_range(16777216, 1))
                                      : 25'($urandom_range(300, 1));
        case ($urandom_range(4))
            0: tb = 48'({$urandom, $urandom});
            1: tb = '0;
            default: tb = 48'(nblk * bb - $urandom_range(bb - 1));
        endcase
        cfg_write(REG_BLOCK, CFG_W'(bb));
        cfg_write(REG_TOTAL, CFG_W'(tb));
        cfg_write(REG_LIMIT, CFG_W'($urandom_range(80, 0)));
        cfg_write(REG_MODE, CFG_W'($urandom_range(9) != 0));
    endtask

    initial begin
        int nitems, n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: one unfinished block over an empty file.
        add_flag(1'b0, 1'b1);
        drain();
        // Bypass, whole file, widest total and a large block size.
        cfg_write(REG_MODE, CFG_W'(0));
        cfg_write(REG_TOTAL, CFG_W'(48'hFFFF_FFFF_FFFF));
        cfg_write(REG_BLOCK, CFG_W'(25'd16777216));
        cfg_write(REG_LIMIT, CFG_W'(7'd64));
        add_flag(1'b1, 1'b0); add_flag(1'b0, 1'b1);
        drain();
        // Planning with splitting; zero block size acts as one byte.
        cfg_write(REG_MODE, CFG_W'(1));
        cfg_write(REG_BLOCK, CFG_W'(25'd0));
        cfg_write(REG_TOTAL, CFG_W'(48'd40));
        cfg_write(REG_LIMIT, CFG_W'(7'd127));
        add_flag(1'b0, 1'b0); add_flag(1'b1, 1'b0); add_flag(1'b0, 1'b0); add_flag(1'b0, 1'b1);
        drain();
        // All finished: empty plan.
        cfg_write(REG_BLOCK, CFG_W'(25'd1));
        add_flag(1'b1, 1'b0); add_flag(1'b1, 1'b1);
        drain();
        // Span table overflow: alternating flags give more than 64 spans.
        cfg_write(REG_TOTAL, CFG_W'(48'd200));
        cfg_write(REG_LIMIT, CFG_W'(7'd1));
        for (int i = 0; i < 130; i++) add_flag(i[0], i == 129);
        drain();
        // Long receiver hold-off while flags keep coming.
        cfg_write(REG_LIMIT, CFG_W'(7'd64));
        cfg_write(REG_BLOCK, CFG_W'(25'd4));
        cfg_write(REG_TOTAL, CFG_W'(48'd400));
        fork
            begin
                rx_hold = 1;
                repeat (600) @(posedge i_clk);
                rx_hold = 0;
            end
        join_none
        add_bitmap(20, 30); add_bitmap(20, 30);
        drain();

        nitems = 0;
        while (nitems < 410) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(100, 40) : $urandom_range(12, 1);
            random_cfg(n);
            quiet = ($urandom_range(5) == 0);
            for (int k = 0; k < 2; k++) add_bitmap(n, $urandom_range(90, 10));
            // Sender pauses until every range is out before the last bitmap.
            wait (flag_q.size() == 0 && !blk_ch.valid);
            tx_hold = 1;
            wait (ranges_q.size() == 0);
            add_bitmap(n, $urandom_range(90, 10));
            tx_hold = 0;
            nitems += 3 * n;
            drain();
        end

        if (errors == 0 && ranges_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/ipl_pkg.sv
design/ipl_in_if.sv
design/ipl_out_if.sv
design/ipl_datapath.sv
design/ipl_ctrl.sv
design/initial_range_planner_top.sv
dv/tb_top.sv
